[src/drp_pkg.sv]
package drp_pkg;

  localparam int unsigned NearW = 21;
  localparam int unsigned RunW  = 16;
  localparam int unsigned DepthW = 16;
  localparam int unsigned CoordW = 10;
  localparam int unsigned BoundW = 16;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [NearW-1:0] NearMax = '1;
  localparam logic [RunW-1:0]  RunMax  = '1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_BOUNDS  = 3'd0,
    CFG_RIGHT_BOUNDS = 3'd1,
    CFG_NEAR_LIMIT   = 3'd2,
    CFG_MIN_OBJECT   = 3'd3,
    CFG_MIN_RUN      = 3'd4
  } cfg_idx_e;

  // Region bounds, starts inclusive, ends exclusive
  typedef struct packed {
    logic [BoundW-1:0] col_end;
    logic [BoundW-1:0] col_start;
    logic [BoundW-1:0] row_end;
    logic [BoundW-1:0] row_start;
  } region_t;

  typedef struct packed {
    region_t            left_bounds;
    region_t            right_bounds;
    logic [DepthW-1:0]  near_limit;
    logic [NearW-1:0]   min_object;
    logic [RunW-1:0]    min_run;
  } drp_cfg_t;

  // Finished frame counts handed from the counter to the judge
  typedef struct packed {
    logic             valid;
    logic [NearW-1:0] left_cnt;
    logic [NearW-1:0] right_cnt;
  } drp_frame_t;

  function automatic logic in_region(region_t b, logic [CoordW-1:0] row,
                                     logic [CoordW-1:0] col);
    logic [BoundW-1:0] r;
    logic [BoundW-1:0] c;
    r = BoundW'(row);
    c = BoundW'(col);
    return (r >= b.row_start) && (r < b.row_end) &&
           (c >= b.col_start) && (c < b.col_end);
  endfunction

endpackage

[src/drp_if.sv]
// Pixel stream channel
interface drp_pix_if;
  import drp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth_raw;
  logic [CoordW-1:0] pixel_row;
  logic [CoordW-1:0] pixel_col;
  logic              frame_end;

  modport source (output valid, depth_raw, pixel_row, pixel_col, frame_end,
                  input ready);
  modport sink (input valid, depth_raw, pixel_row, pixel_col, frame_end,
                output ready);
endinterface

// Per-frame result channel
interface drp_res_if;
  import drp_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      alert;
  logic            left_occupied;
  logic            right_occupied;
  logic [RunW-1:0] left_run;
  logic [RunW-1:0] right_run;

  modport source (output valid, alert, left_occupied, right_occupied, left_run, right_run,
                  input ready);
  modport sink (input valid, alert, left_occupied, right_occupied, left_run, right_run,
                output ready);
endinterface

[src/drp_region_count.sv]
module drp_region_count import drp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drp_pix_if.sink     pix_i,
  input  drp_cfg_t    cfg_i,
  input  logic        judge_free_i,
  output drp_frame_t  frame_o
);

  localparam logic [CoordW:0] FrameCols = (CoordW+1)'(FRAME_WIDTH);
  localparam logic [CoordW:0] FrameRows = (CoordW+1)'(FRAME_HEIGHT);

  logic              s0_valid_q, s0_valid_d;
  logic [DepthW-1:0] s0_depth_q;
  logic [CoordW-1:0] s0_row_q;
  logic [CoordW-1:0] s0_col_q;
  logic              s0_last_q;

  logic [NearW-1:0] left_cnt_q, left_cnt_d, left_next;
  logic [NearW-1:0] right_cnt_q, right_cnt_d, right_next;

  logic accept, proc, in_frame, near, hit_l, hit_r;

  // A frame-end pixel waits until the judge stage is free
  assign proc        = s0_valid_q && (!s0_last_q || judge_free_i);
  assign pix_i.ready = !s0_valid_q || proc;
  assign accept      = pix_i.valid && pix_i.ready;

  // Classify the held pixel
  assign in_frame = ({1'b0, s0_row_q} < FrameRows) && ({1'b0, s0_col_q} < FrameCols);
  assign near     = s0_depth_q <= cfg_i.near_limit;
  assign hit_l    = in_frame && near && in_region(cfg_i.left_bounds, s0_row_q, s0_col_q);
  assign hit_r    = in_frame && near && in_region(cfg_i.right_bounds, s0_row_q, s0_col_q);

  // Saturating count update; counts clear when a frame-end pixel is processed
  always_comb begin
    left_next  = left_cnt_q;
    right_next = right_cnt_q;
    if (hit_l && left_cnt_q != NearMax) left_next = left_cnt_q + NearW'(1);
    if (hit_r && right_cnt_q != NearMax) right_next = right_cnt_q + NearW'(1);

    left_cnt_d  = left_cnt_q;
    right_cnt_d = right_cnt_q;
    if (proc) begin
      left_cnt_d  = s0_last_q ? '0 : left_next;
      right_cnt_d = s0_last_q ? '0 : right_next;
    end

    s0_valid_d = accept ? 1'b1 : (proc ? 1'b0 : s0_valid_q);
  end

  // Hand finished counts to the judge
  assign frame_o.valid     = proc && s0_last_q;
  assign frame_o.left_cnt  = left_next;
  assign frame_o.right_cnt = right_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      left_cnt_q  <= left_cnt_d;
      right_cnt_q <= right_cnt_d;
    end
  end

  // Capture the pixel on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_depth_q <= pix_i.depth_raw;
      s0_row_q   <= pix_i.pixel_row;
      s0_col_q   <= pix_i.pixel_col;
      s0_last_q  <= pix_i.frame_end;
    end
  end

endmodule

[src/drp_frame_judge.sv]
module drp_frame_judge import drp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  drp_frame_t frame_i,
  input  drp_cfg_t   cfg_i,
  output logic       judge_free_o,
  drp_res_if.source  res_o
);

  logic             j_valid_q, j_valid_d;
  logic [NearW-1:0] j_left_q, j_right_q;

  logic [RunW-1:0] left_run_q, left_run_d;
  logic [RunW-1:0] right_run_q, right_run_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_alert_q;
  logic            out_left_occ_q, out_right_occ_q;

  logic o_load, occ_l, occ_r;
  logic [1:0] alert;

  // Move the held frame to the result register when it is free
  assign o_load       = j_valid_q && (!out_valid_q || res_o.ready);
  assign judge_free_o = !j_valid_q || o_load;

  // Judge occupancy, advance runs, derive alert
  always_comb begin
    occ_l = j_left_q >= cfg_i.min_object;
    occ_r = j_right_q >= cfg_i.min_object;

    left_run_d  = left_run_q;
    right_run_d = right_run_q;
    if (o_load) begin
      left_run_d  = !occ_l ? '0 : ((left_run_q == RunMax) ? RunMax : left_run_q + RunW'(1));
      right_run_d = !occ_r ? '0 : ((right_run_q == RunMax) ? RunMax : right_run_q + RunW'(1));
    end

    alert[0] = left_run_d >= cfg_i.min_run;
    alert[1] = right_run_d >= cfg_i.min_run;

    j_valid_d   = frame_i.valid ? 1'b1 : (o_load ? 1'b0 : j_valid_q);
    out_valid_d = o_load ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      left_run_q  <= '0;
      right_run_q <= '0;
    end else begin
      j_valid_q   <= j_valid_d;
      out_valid_q <= out_valid_d;
      left_run_q  <= left_run_d;
      right_run_q <= right_run_d;
    end
  end

  // Hold frame counts and result payload
  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      j_left_q  <= frame_i.left_cnt;
      j_right_q <= frame_i.right_cnt;
    end
    if (o_load) begin
      out_alert_q     <= alert;
      out_left_occ_q  <= occ_l;
      out_right_occ_q <= occ_r;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.alert          = out_alert_q;
  assign res_o.left_occupied  = out_left_occ_q;
  assign res_o.right_occupied = out_right_occ_q;
  assign res_o.left_run       = left_run_q;
  assign res_o.right_run      = right_run_q;

endmodule

[src/depth_roi_proximity_alert_top.sv]
// Channel   | Dir | Handshake     | Payload
// pix_i     | in  | valid/ready   | depth_raw, pixel_row, pixel_col, frame_end
// res_o     | out | valid/ready   | alert, left/right_occupied, left/right_run
// cfg       | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// One pixel is taken every cycle unless a frame-end pixel waits; each pixel is held in the input register.
// A frame result passes from the input register through the judge frame register to the result register.
// Reset clears configuration, near counts and run counts.
// A stalled result holds only frame-end pixels and the pixels behind a held one; other pixels keep flowing.
module depth_roi_proximity_alert_top import drp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  drp_pix_if.sink             pix_i,
  drp_res_if.source           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  drp_cfg_t   cfg_q;
  drp_frame_t frame;
  logic       judge_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_BOUNDS:  cfg_q.left_bounds  <= region_t'(cfg_data_i);
        CFG_RIGHT_BOUNDS: cfg_q.right_bounds <= region_t'(cfg_data_i);
        CFG_NEAR_LIMIT:   cfg_q.near_limit   <= cfg_data_i[DepthW-1:0];
        CFG_MIN_OBJECT:   cfg_q.min_object   <= cfg_data_i[NearW-1:0];
        CFG_MIN_RUN:      cfg_q.min_run      <= cfg_data_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  drp_region_count #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .cfg_i        (cfg_q),
    .judge_free_i (judge_free),
    .frame_o      (frame)
  );

  drp_frame_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .cfg_i        (cfg_q),
    .judge_free_o (judge_free),
    .res_o        (res_o)
  );

endmodule

[tb/tb_depth_roi_proximity_alert_top.sv]
`timescale 1ns / 100ps

// Expected outcome of one finished frame
typedef struct packed {
  logic [1:0]               alert;
  logic                     left_occ;
  logic                     right_occ;
  logic [drp_pkg::RunW-1:0] left_run;
  logic [drp_pkg::RunW-1:0] right_run;
} frame_verdict_t;

// Tracks near counts and run lengths, and queues the verdict of each frame end
class frame_verdict_board;
  int unsigned                 frame_w;
  int unsigned                 frame_h;
  drp_pkg::region_t            left_box;
  drp_pkg::region_t            right_box;
  logic [drp_pkg::DepthW-1:0]  near_limit;
  logic [drp_pkg::NearW-1:0]   min_object;
  logic [drp_pkg::RunW-1:0]    min_run;
  logic [drp_pkg::NearW-1:0]   left_near;
  logic [drp_pkg::NearW-1:0]   right_near;
  logic [drp_pkg::RunW-1:0]    left_run;
  logic [drp_pkg::RunW-1:0]    right_run;
  frame_verdict_t              verdicts_due[$];
  int unsigned                 mismatches;

  function new(int unsigned width, int unsigned height);
    frame_w    = width;
    frame_h    = height;
    left_box   = '0;
    right_box  = '0;
    near_limit = '0;
    min_object = '0;
    min_run    = '0;
    left_near  = '0;
    right_near = '0;
    left_run   = '0;
    right_run  = '0;
    mismatches = 0;
  endfunction

  // Mirror a register write; unmapped indexes are dropped
  function void set_reg(logic [drp_pkg::CfgIdxW-1:0] idx,
                        logic [drp_pkg::CfgDataW-1:0] data);
    case (idx)
      drp_pkg::CFG_LEFT_BOUNDS:  left_box   = data;
      drp_pkg::CFG_RIGHT_BOUNDS: right_box  = data;
      drp_pkg::CFG_NEAR_LIMIT:   near_limit = data[drp_pkg::DepthW-1:0];
      drp_pkg::CFG_MIN_OBJECT:   min_object = data[drp_pkg::NearW-1:0];
      drp_pkg::CFG_MIN_RUN:      min_run    = data[drp_pkg::RunW-1:0];
      default: ;
    endcase
  endfunction

  static function bit holds_pixel(drp_pkg::region_t b, logic [drp_pkg::CoordW-1:0] row,
                                  logic [drp_pkg::CoordW-1:0] col);
    int unsigned r;
    int unsigned c;
    r = row;
    c = col;
    return r >= b.row_start && r < b.row_end && c >= b.col_start && c < b.col_end;
  endfunction

  // Count an accepted pixel, then judge the frame if it ends here
  function void take_pixel(logic [drp_pkg::DepthW-1:0] depth, logic [drp_pkg::CoordW-1:0] row,
                           logic [drp_pkg::CoordW-1:0] col, logic last);
    frame_verdict_t v;
    if (row < frame_h && col < frame_w && depth <= near_limit) begin
      if (holds_pixel(left_box, row, col) && left_near != drp_pkg::NearMax) left_near++;
      if (holds_pixel(right_box, row, col) && right_near != drp_pkg::NearMax) right_near++;
    end
    if (!last) return;
    v.left_occ  = left_near >= min_object;
    v.right_occ = right_near >= min_object;
    if (!v.left_occ) begin
      left_run = '0;
    end else if (left_run != drp_pkg::RunMax) begin
      left_run++;
    end
    if (!v.right_occ) begin
      right_run = '0;
    end else if (right_run != drp_pkg::RunMax) begin
      right_run++;
    end
    left_near   = '0;
    right_near  = '0;
    v.alert     = {right_run >= min_run, left_run >= min_run};
    v.left_run  = left_run;
    v.right_run = right_run;
    verdicts_due.push_back(v);
  endfunction

  // Compare one result transfer against the oldest pending verdict
  function void match_verdict(logic [1:0] alert, logic left_occ, logic right_occ,
                              logic [drp_pkg::RunW-1:0] l_run,
                              logic [drp_pkg::RunW-1:0] r_run);
    frame_verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("result with no frame end pending: alert %0d left_run %0d right_run %0d",
             alert, l_run, r_run);
      mismatches++;
      return;
    end
    want = verdicts_due.pop_front();
    if (alert !== want.alert) begin
      $error("alert: expected %0d, got %0d", want.alert, alert);
      mismatches++;
    end
    if (left_occ !== want.left_occ) begin
      $error("left_occupied: expected %0d, got %0d", want.left_occ, left_occ);
      mismatches++;
    end
    if (right_occ !== want.right_occ) begin
      $error("right_occupied: expected %0d, got %0d", want.right_occ, right_occ);
      mismatches++;
    end
    if (l_run !== want.left_run) begin
      $error("left_run: expected %0d, got %0d", want.left_run, l_run);
      mismatches++;
    end
    if (r_run !== want.right_run) begin
      $error("right_run: expected %0d, got %0d", want.right_run, r_run);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return verdicts_due.size();
  endfunction
endclass

module tb_depth_roi_proximity_alert_top;
  import drp_pkg::*;

  localparam int unsigned FrameWidth     = 640;
  localparam int unsigned FrameHeight    = 480;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned PixelsPerPhase = 76;
  localparam int unsigned StreakFrames   = 24;
  localparam logic [CfgIdxW-1:0] FirstUnmappedIdx = CfgIdxW'(CFG_MIN_RUN + 1);

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  drp_pix_if pix ();
  drp_res_if res ();

  frame_verdict_board board;
  bit                 steady = 1'b0;
  int unsigned        idle_cycles = 0;

  depth_roi_proximity_alert_top #(
    .FRAME_WIDTH (FrameWidth),
    .FRAME_HEIGHT(FrameHeight)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pack bounds as row start, row end, column start, column end from the low bits
  function automatic region_t box(logic [BoundW-1:0] r0, logic [BoundW-1:0] r1,
                                  logic [BoundW-1:0] c0, logic [BoundW-1:0] c1);
    return {c1, c0, r1, r0};
  endfunction

  function automatic region_t random_region();
    region_t           b;
    logic [BoundW-1:0] r0;
    logic [BoundW-1:0] c0;
    r0 = BoundW'($urandom_range(0, 500));
    c0 = BoundW'($urandom_range(0, 660));
    case ($urandom_range(0, 9))
      0:       b = {$urandom, $urandom};
      1:       b = box(BoundW'(r0 + 20), r0, c0, BoundW'(c0 + 50));
      2:       b = box(0, '1, 0, '1);
      default: b = box(r0, BoundW'(r0 + $urandom_range(1, 300)), c0,
                       BoundW'(c0 + $urandom_range(1, 400)));
    endcase
    return b;
  endfunction

  // Coordinate inside [lo, hi) where possible, sometimes right on an edge
  function automatic logic [CoordW-1:0] pick_coord(logic [BoundW-1:0] lo,
                                                   logic [BoundW-1:0] hi);
    int unsigned top;
    top = (hi > 1024) ? 1024 : hi;
    case ($urandom_range(0, 9))
      0: return lo[CoordW-1:0];
      1: return hi[CoordW-1:0];
      default: begin
        if (lo < top) return CoordW'($urandom_range(lo, top - 1));
        return CoordW'($urandom);
      end
    endcase
  endfunction

  // Write one register at the next rising edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one pixel after a random gap and hold it until the transfer
  task automatic push_pixel(logic [DepthW-1:0] depth, logic [CoordW-1:0] row,
                            logic [CoordW-1:0] col, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid     = 1'b1;
    pix.depth_raw = depth;
    pix.pixel_row = row;
    pix.pixel_col = col;
    pix.frame_end = last;
    do @(posedge clk_i); while (!pix.ready);
    board.take_pixel(depth, row, col, last);
    @(negedge clk_i);
  endtask

  // Stop sending, wait out pending results and the pipeline behind them
  task automatic drain_frames();
    pix.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // New random settings, then frames of random length aimed mostly at the regions
  task automatic random_phase(int unsigned pixels);
    region_t             l_box;
    region_t             r_box;
    logic [DepthW-1:0]   lim;
    logic [NearW-1:0]    obj;
    logic [RunW-1:0]     run;
    logic [CfgDataW-1:0] junk;
    logic [DepthW-1:0]   depth;
    logic [CoordW-1:0]   row;
    logic [CoordW-1:0]   col;
    region_t             aim;
    int unsigned         sent;
    int unsigned         len;
    l_box = random_region();
    r_box = random_region();
    junk  = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       lim = '0;
      1:       lim = '1;
      default: lim = DepthW'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       obj = '0;
      1:       obj = NearW'($urandom);
      default: obj = NearW'($urandom_range(1, 5));
    endcase
    case ($urandom_range(0, 7))
      0:       run = '0;
      1:       run = '1;
      2:       run = RunW'($urandom);
      default: run = RunW'($urandom_range(1, 3));
    endcase
    write_reg(CFG_LEFT_BOUNDS, l_box);
    write_reg(CFG_RIGHT_BOUNDS, r_box);
    write_reg(CFG_NEAR_LIMIT, {junk[CfgDataW-1:DepthW], lim});
    write_reg(CFG_MIN_OBJECT, {junk[CfgDataW-1:NearW], obj});
    write_reg(CFG_MIN_RUN, {junk[CfgDataW-1:RunW], run});
    sent = 0;
    while (sent < pixels) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        aim = $urandom_range(0, 1) ? l_box : r_box;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            row = pick_coord(aim.row_start, aim.row_end);
            col = pick_coord(aim.col_start, aim.col_end);
          end
          6, 7: begin
            row = CoordW'($urandom_range(0, FrameHeight - 1));
            col = CoordW'($urandom_range(0, FrameWidth - 1));
          end
          default: begin
            row = CoordW'($urandom);
            col = CoordW'($urandom);
          end
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: depth = DepthW'($urandom_range(0, lim));
          5:             depth = lim;
          6:             depth = DepthW'(lim + 1);
          default:       depth = DepthW'($urandom);
        endcase
        push_pixel(depth, row, col, i == len - 1);
        sent++;
      end
    end
  endtask

  // Result sink: random stalls, long stretches of steady acceptance
  initial begin
    int unsigned stall;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res.ready = 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      board.match_verdict(res.alert, res.left_occupied, res.right_occupied,
                          res.left_run, res.right_run);
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("depth_roi_proximity_alert_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    board         = new(FrameWidth, FrameHeight);
    rst_ni        = 1'b0;
    pix.valid     = 1'b0;
    pix.depth_raw = '0;
    pix.pixel_row = '0;
    pix.pixel_col = '0;
    pix.frame_end = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Overlapping halves: limit edges, frame edges, pixels outside the frame
    write_reg(CFG_LEFT_BOUNDS, box(0, 480, 0, 400));
    write_reg(CFG_RIGHT_BOUNDS, box(0, 480, 300, 640));
    write_reg(CFG_NEAR_LIMIT, 1000);
    write_reg(CFG_MIN_OBJECT, 2);
    write_reg(CFG_MIN_RUN, 2);
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(1000, 10, 350, 1'b0);
    push_pixel(1001, 10, 350, 1'b0);
    push_pixel(0, 479, 639, 1'b0);
    push_pixel(0, 480, 100, 1'b0);
    push_pixel(0, 100, 640, 1'b0);
    push_pixel(16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
    // The frame end pixel itself completes the right count
    push_pixel(0, 30, 600, 1'b0);
    push_pixel(5, 20, 500, 1'b1);
    drain_frames();

    // Zero thresholds with an empty and an inverted region
    write_reg(CFG_LEFT_BOUNDS, box(7, 7, 0, 640));
    write_reg(CFG_RIGHT_BOUNDS, box(300, 100, 500, 20));
    write_reg(CFG_NEAR_LIMIT, 16'hFFFF);
    write_reg(CFG_MIN_OBJECT, 0);
    write_reg(CFG_MIN_RUN, 0);
    push_pixel(16'hFFFF, 7, 5, 1'b1);
    push_pixel(0, 200, 300, 1'b1);
    drain_frames();

    // All-ones writes, widest region, unmapped indexes
    write_reg(CFG_LEFT_BOUNDS, '1);
    write_reg(CFG_RIGHT_BOUNDS, box(0, 16'hFFFF, 0, 16'hFFFF));
    write_reg(CFG_NEAR_LIMIT, '0);
    write_reg(CFG_MIN_OBJECT, '1);
    write_reg(CFG_MIN_RUN, '1);
    for (int unsigned k = 0; k < 3; k++) begin
      write_reg(CfgIdxW'(FirstUnmappedIdx + k), {$urandom, $urandom});
    end
    push_pixel(0, 5, 5, 1'b0);
    push_pixel(0, 479, 639, 1'b0);
    push_pixel(0, 10'h3FF, 10'h3FF, 1'b1);
    drain_frames();

    // Random settings and traffic, some phases without idling
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      random_phase(PixelsPerPhase);
      drain_frames();
    end

    // Build a streak of occupied frames on both sides, then clear it
    steady = 1'b1;
    write_reg(CFG_MIN_OBJECT, 0);
    write_reg(CFG_MIN_RUN, '1);
    repeat (StreakFrames) begin
      push_pixel(DepthW'($urandom), CoordW'($urandom), CoordW'($urandom), 1'b1);
    end
    drain_frames();
    steady = 1'b0;
    write_reg(CFG_MIN_OBJECT, '1);
    push_pixel(0, 0, 0, 1'b1);
    drain_frames();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("depth_roi_proximity_alert_top verification clean");
    end else begin
      $display("depth_roi_proximity_alert_top verification failed");
    end
    $finish;
  end
endmodule
